// ===== rtl/ssat_pkg.sv =====
// shared types, register map and constants for the stereo sine saturator
// also holds the sine table generator used by the lane rom
// depends on nothing
package ssat_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int FRAC_W          = SAMPLE_W - 1;
	localparam int SINE_TABLE_BITS = 10;
	localparam int INTERP_W        = 16;
	localparam int TAB_W           = 31;
	localparam int LANE_STAGES     = 10;
	localparam int ADDR_W          = 4;
	localparam int DATA_W          = 32;

	localparam logic [15:0] PHASE_SCALE  = 16'd41722;
	localparam longint      HALF_PI_Q30  = 64'sd1686629713;
	localparam longint      ONE_Q30      = 64'sd1073741824;

	localparam logic [15:0] INPUT_GAIN_RST  = 16'd4096;
	localparam logic [15:0] DRIVE_ANGLE_RST = 16'd0;
	localparam logic [19:0] NORM_GAIN_RST   = 20'd0;
	localparam logic [15:0] OUTPUT_GAIN_RST = 16'd4096;

	typedef enum logic [1:0] {
		REG_INPUT_GAIN  = 2'd0,
		REG_DRIVE_ANGLE = 2'd1,
		REG_NORM_GAIN   = 2'd2,
		REG_OUTPUT_GAIN = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
	} out_t;

	typedef struct packed {
		logic [15:0] input_gain;
		logic [15:0] drive_angle;
		logic [19:0] norm_gain;
		logic [15:0] output_gain;
	} cfg_t;

	// truncating quotient of non-negative values by shift and subtract,
	// evaluated only while the rom is built
	function automatic longint quot_pos(input longint n, input longint d);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((n >>> b) & longint'(1));
			if (r >= d) begin
				r = r - d;
				q = q | (longint'(1) <<< b);
			end
		end
		return q;
	endfunction

	// quarter-wave sine entry in q1.30, taylor series to x^19
	function automatic logic [TAB_W-1:0] sine_entry(input int i, input int bits);
		longint x;
		longint x2;
		longint term;
		longint sum;
		x = (longint'(i) * HALF_PI_Q30) >>> bits;
		x2 = (x * x) >>> 30;
		term = x;
		sum = x;
		for (int k = 1; k <= 9; k++) begin
			term = quot_pos((term * x2) >>> 30, longint'((2 * k) * (2 * k + 1)));
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end else if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		return sum[TAB_W-1:0];
	endfunction

endpackage

// ===== rtl/ssat_regs.sv =====
// apb-style configuration register file for the stereo sine saturator
// depends on ssat_pkg
module ssat_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssat_pkg::ADDR_W-1:0]   paddr,
	input  logic [ssat_pkg::DATA_W-1:0]   pwdata,
	output logic [ssat_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output ssat_pkg::cfg_t                cfg
);

	ssat_pkg::cfg_t     cfg_q;
	ssat_pkg::reg_idx_t idx;
	logic               wr;

	assign pready = 1'b1;
	assign idx    = ssat_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_gain  <= ssat_pkg::INPUT_GAIN_RST;
			cfg_q.drive_angle <= ssat_pkg::DRIVE_ANGLE_RST;
			cfg_q.norm_gain   <= ssat_pkg::NORM_GAIN_RST;
			cfg_q.output_gain <= ssat_pkg::OUTPUT_GAIN_RST;
		end else if (wr) begin
			case (idx)
				ssat_pkg::REG_INPUT_GAIN:  cfg_q.input_gain  <= pwdata[15:0];
				ssat_pkg::REG_DRIVE_ANGLE: cfg_q.drive_angle <= pwdata[15:0];
				ssat_pkg::REG_NORM_GAIN:   cfg_q.norm_gain   <= pwdata[19:0];
				ssat_pkg::REG_OUTPUT_GAIN: cfg_q.output_gain <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			ssat_pkg::REG_INPUT_GAIN:  prdata = {16'd0, cfg_q.input_gain};
			ssat_pkg::REG_DRIVE_ANGLE: prdata = {16'd0, cfg_q.drive_angle};
			ssat_pkg::REG_NORM_GAIN:   prdata = {12'd0, cfg_q.norm_gain};
			ssat_pkg::REG_OUTPUT_GAIN: prdata = {16'd0, cfg_q.output_gain};
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== rtl/ssat_lane.sv =====
// one channel of the saturator: gain, clamp, sine lookup with interpolation,
// normalize, output gain; ten register stages gated by a shared enable
// depends on ssat_pkg
module ssat_lane #(
	parameter int TABLE_BITS = ssat_pkg::SINE_TABLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  ssat_pkg::cfg_t                       cfg,
	input  logic signed [ssat_pkg::SAMPLE_W-1:0] x,
	output logic signed [ssat_pkg::SAMPLE_W-1:0] y
);

	localparam int TAB_N    = 1 << TABLE_BITS;
	localparam int PB       = TABLE_BITS + ssat_pkg::INTERP_W;
	localparam int PH_SHIFT = 29 - TABLE_BITS;
	localparam int TW       = ssat_pkg::TAB_W;
	localparam int IW       = ssat_pkg::INTERP_W;

	typedef logic [TW-1:0] rom_t [0:TAB_N+1];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i <= TAB_N; i++) begin
			r[i] = ssat_pkg::sine_entry(i, TABLE_BITS);
		end
		r[TAB_N+1] = r[TAB_N];
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	localparam logic signed [32:0] LIM_P = 33'sd1 <<< 27;
	localparam logic signed [52:0] LIM_Y = 53'sd1 <<< 42;
	localparam logic signed [21:0] SAT_HI = 22'sd32767;
	localparam logic signed [21:0] SAT_LO = -22'sd32768;

	// stage registers
	logic signed [32:0] p_s1;
	logic        [15:0] mag_s2;
	logic               neg_s2;
	logic        [31:0] m_s3;
	logic               neg_s3;
	logic        [47:0] ph_s4;
	logic               neg_s4;
	logic      [TW-1:0] t0_s5;
	logic      [TW-1:0] t1_s5;
	logic      [IW-1:0] fr_s5;
	logic               neg_s5;
	logic signed [48:0] prod_s6;
	logic      [TW-1:0] t0_s6;
	logic               neg_s6;
	logic signed [31:0] sv_s7;
	logic signed [52:0] y_s8;
	logic signed [16:0] z_s9;
	logic signed [33:0] w_s10;

	// stage logic
	logic signed [32:0] pc;
	logic signed [16:0] u;
	logic         [1:0] quad;
	logic      [PB-1:0] pos;
	logic        [PB:0] pos_m;
	logic  [TABLE_BITS:0] idx;
	logic  [TABLE_BITS:0] idx1;
	logic signed [31:0] diff;
	logic signed [32:0] inc;
	logic signed [32:0] sum;
	logic signed [52:0] yc;
	logic signed [21:0] v;

	always_comb begin
		if (p_s1 > LIM_P) begin
			pc = LIM_P;
		end else if (p_s1 < -LIM_P) begin
			pc = -LIM_P;
		end else begin
			pc = p_s1;
		end
		u = pc[28:12];
	end

	// phase bits above the quadrant wrap away; odd quadrants are mirrored
	always_comb begin
		quad  = ph_s4[46:45];
		pos   = ph_s4[44:PH_SHIFT];
		pos_m = quad[0] ? ({1'b1, {PB{1'b0}}} - {1'b0, pos}) : {1'b0, pos};
		idx   = pos_m[PB:IW];
		idx1  = idx + 1'b1;
	end

	assign diff = $signed({1'b0, t1_s5}) - $signed({1'b0, t0_s5});
	assign inc  = prod_s6[48:16];
	assign sum  = $signed({2'b00, t0_s6}) + inc;

	always_comb begin
		if (y_s8 > LIM_Y) begin
			yc = LIM_Y;
		end else if (y_s8 < -LIM_Y) begin
			yc = -LIM_Y;
		end else begin
			yc = y_s8;
		end
	end

	always_comb begin
		v = w_s10[33:12];
		if (v > SAT_HI) begin
			y = SAT_HI[15:0];
		end else if (v < SAT_LO) begin
			y = SAT_LO[15:0];
		end else begin
			y = v[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= x * $signed({1'b0, cfg.input_gain});
			mag_s2  <= u[16] ? 16'(-u) : u[15:0];
			neg_s2  <= u[16];
			m_s3    <= mag_s2 * cfg.drive_angle;
			neg_s3  <= neg_s2;
			ph_s4   <= m_s3 * ssat_pkg::PHASE_SCALE;
			neg_s4  <= neg_s3;
			t0_s5   <= ROM[idx];
			t1_s5   <= ROM[idx1];
			fr_s5   <= pos_m[IW-1:0];
			neg_s5  <= neg_s4 ^ quad[1];
			prod_s6 <= diff * $signed({1'b0, fr_s5});
			t0_s6   <= t0_s5;
			neg_s6  <= neg_s5;
			sv_s7   <= neg_s6 ? 32'(-sum) : sum[31:0];
			y_s8    <= sv_s7 * $signed({1'b0, cfg.norm_gain});
			z_s9    <= yc[43:27];
			w_s10   <= z_s9 * $signed({1'b0, cfg.output_gain});
		end
	end

endmodule

// ===== rtl/ssat_merge.sv =====
// valid tracking for the lane pipeline and the output register that
// joins both lane results into one transaction; depends on ssat_pkg
module ssat_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	output logic                                 en,
	input  logic signed [ssat_pkg::SAMPLE_W-1:0] left_res,
	input  logic signed [ssat_pkg::SAMPLE_W-1:0] right_res,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output ssat_pkg::out_t                       out_data
);

	localparam int ST = ssat_pkg::LANE_STAGES;

	logic [ST-1:0]  vld_q;
	logic           out_valid_q;
	ssat_pkg::out_t out_data_q;

	// whole pipeline holds only while a finished result is refused
	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[ST-2:0], in_valid};
			out_valid_q <= vld_q[ST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_q[ST-1]) begin
			out_data_q.left_out  <= left_res;
			out_data_q.right_out <= right_res;
		end
	end

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid chain moved during a stall");

	a_arrive: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_q[ST-1] |=> out_valid_q)
		else $error("last lane stage lost its result");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_stall && !vld_q[ST-1] |=> !out_valid_q)
		else $error("output repeated after it was taken");

endmodule

// ===== rtl/stereo_sine_saturator_top.sv =====
// stereo sine saturator, top level
// an accepted input transaction passes the ten lane stages and then the
// output register before output valid rises; throughput one stereo pair
// per cycle, limited by nothing but output stall, which freezes the pipeline
// reset (arst_n low, asynchronous) empties the pipeline and loads register
// defaults: input and output gain 1.0, drive angle and norm gain zero
module stereo_sine_saturator_top #(
	parameter int TABLE_BITS = ssat_pkg::SINE_TABLE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  ssat_pkg::in_t               in_data,
	// sample output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output ssat_pkg::out_t              out_data,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssat_pkg::ADDR_W-1:0] paddr,
	input  logic [ssat_pkg::DATA_W-1:0] pwdata,
	output logic [ssat_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	ssat_pkg::cfg_t                       cfg;
	logic                                 en;
	logic signed [ssat_pkg::SAMPLE_W-1:0] left_res;
	logic signed [ssat_pkg::SAMPLE_W-1:0] right_res;

	// gain, drive, normalizer and output gain registers
	ssat_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// two identical lanes, one per channel, each with its own sine rom
	ssat_lane #(.TABLE_BITS(TABLE_BITS)) u_lane_l (
		.clk (clk),
		.en  (en),
		.cfg (cfg),
		.x   (in_data.left_in),
		.y   (left_res)
	);

	ssat_lane #(.TABLE_BITS(TABLE_BITS)) u_lane_r (
		.clk (clk),
		.en  (en),
		.cfg (cfg),
		.x   (in_data.right_in),
		.y   (right_res)
	);

	// valid chain and output register join both lanes into one transaction
	ssat_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.en        (en),
		.left_res  (left_res),
		.right_res (right_res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
